@@ src/vec4_vector_alu_core_macros.svh @@
// Assertion macros shared by the vector ALU checker.
`ifndef VEC4_VECTOR_ALU_CORE_MACROS_SVH
`define VEC4_VECTOR_ALU_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define V4A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define V4A_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/v4a_pkg.sv @@
// Shared types, opcodes and widths of the four-component vector ALU.
`default_nettype none

package v4a_pkg;

  localparam int unsigned CompWidth       = 32;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned TolWidth        = 31;
  localparam logic [TolWidth-1:0] TolReset = 31'd66;
  localparam int unsigned RootBits        = 34;
  localparam int unsigned SqWidth         = 2 * CompWidth - 1;
  localparam int unsigned SumWidth        = 2 * CompWidth + 1;
  localparam int unsigned DotWidth        = 2 * CompWidth + 2;
  localparam int unsigned OpWidth         = 3;
  localparam int unsigned InWidth         = 264;
  localparam int unsigned OutWidth        = 136;
  localparam int unsigned AddrWidth       = 3;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_DOT  = 3'd2,
    OP_LEN  = 3'd3,
    OP_NORM = 3'd4,
    OP_NEAR = 3'd5,
    OP_EQ   = 3'd6
  } op_t;

  // Per-item context carried down the pipeline.
  typedef struct packed {
    op_t                              op;
    logic [3:0]                       neg;
    logic [3:0][CompWidth-1:0]        vec;
    logic                             vfault;
    logic                             match;
    logic signed [DotWidth-1:0]       dot;
    logic [SumWidth-1:0]              ssq;
    logic [3:0][SqWidth-1:0]          sq;
  } ctx_t;

endpackage

`default_nettype wire

@@ src/vec4_vector_alu_core.sv @@
// An item passes the front end, the 34 square-root digit stages and the output stage.
// Throughput: one item per cycle unless the output stalls; depth is set by the digit stages.
// The pipeline moves as one; it stalls only while a result item waits to be taken.
// Reset (rst, synchronous) clears all valid bits and sets tolerance to 66.
// Payload registers are not reset.
`default_nettype none

module vec4_vector_alu_core #(
  parameter int unsigned FRAC_BITS = v4a_pkg::FracBitsDefault
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input items.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // op[2:0], a_x[34:3], a_y[66:35], a_z[98:67], a_w[130:99],
  // b_x[162:131], b_y[194:163], b_z[226:195], b_w[258:227], zero fill above.
  input  wire logic [v4a_pkg::InWidth-1:0]      s_tdata,
  // Result items.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // r_x[31:0], r_y[63:32], r_z[95:64], r_w[127:96], match[128], fault[129],
  // zero fill above.
  output logic [v4a_pkg::OutWidth-1:0]          m_tdata,
  // Configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [v4a_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import v4a_pkg::*;

  localparam int unsigned NW = 2 * FRAC_BITS + 68;
  localparam int unsigned UW = FRAC_BITS + 66;

  logic [TolWidth-1:0] tolerance;
  logic                en;

  // Chain between the digit-search stages: index 0 is the front end's output.
  logic                    v_c    [RootBits+1];
  ctx_t                    ctx_c  [RootBits+1];
  logic [RootBits-1:0]     root_c [RootBits+1];
  logic [SumWidth-1:0]     rsq_c  [RootBits+1];
  logic [3:0][NW-1:0]      t_c    [RootBits+1];
  logic [3:0][UW-1:0]      u_c    [RootBits+1];
  logic [3:0][FRAC_BITS:0] q_c    [RootBits+1];

  // Everything advances together unless the output holds a result that is not taken.
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // The tolerance register sits at byte address 0; word address 1 reads as zero.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {1'b0, tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TolReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tolerance <= pwdata[TolWidth-1:0];
    end
  end

  v4a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .tolerance (tolerance),
    .out_valid (v_c[0]),
    .out_ctx   (ctx_c[0])
  );

  // The searches start from zero for every item.
  assign root_c[0] = '0;
  assign rsq_c[0] = '0;
  assign t_c[0] = '0;
  assign u_c[0] = '0;
  assign q_c[0] = '0;

  // One stage per root bit; the normalize search runs in the first FRAC_BITS+1 of them.
  for (genvar k = 0; k < RootBits; k++) begin : g_iter
    v4a_iter #(
      .FRAC_BITS (FRAC_BITS),
      .STAGE     (k)
    ) u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_c[k]),
      .in_ctx    (ctx_c[k]),
      .in_root   (root_c[k]),
      .in_rsq    (rsq_c[k]),
      .in_t      (t_c[k]),
      .in_u      (u_c[k]),
      .in_q      (q_c[k]),
      .out_valid (v_c[k+1]),
      .out_ctx   (ctx_c[k+1]),
      .out_root  (root_c[k+1]),
      .out_rsq   (rsq_c[k+1]),
      .out_t     (t_c[k+1]),
      .out_u     (u_c[k+1]),
      .out_q     (q_c[k+1])
    );
  end

  v4a_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_c[RootBits]),
    .in_ctx    (ctx_c[RootBits]),
    .in_root   (root_c[RootBits]),
    .in_q      (q_c[RootBits]),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

@@ src/v4a_front.sv @@
// Front end: multipliers, add and subtract, compares, and the two-level sum trees.
`default_nettype none

module v4a_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [v4a_pkg::InWidth-1:0]     in_data,
  input  wire logic [v4a_pkg::TolWidth-1:0]    tolerance,
  output logic                                 out_valid,
  output v4a_pkg::ctx_t                        out_ctx
);
  import v4a_pkg::*;

  logic signed [CompWidth-1:0]   a [4];
  logic signed [CompWidth-1:0]   b [4];
  logic signed [CompWidth:0]     sum [4];
  logic signed [CompWidth:0]     diff [4];
  logic        [CompWidth:0]     dmag [4];
  logic signed [2*CompWidth-1:0] prod [4];
  logic signed [2*CompWidth-1:0] sqr [4];
  op_t                           op;
  logic [3:0]                    near_ok;
  logic [3:0]                    eq_ok;
  ctx_t                          ctx0;
  ctx_t                          ctx3;

  // Stage registers.
  logic                          v1, v2;
  ctx_t                          c1, c2;
  logic signed [2*CompWidth-1:0] p1 [4];
  logic signed [2*CompWidth:0]   dp2 [2];
  logic        [2*CompWidth-1:0] sp2 [2];

  always_comb begin
    op = op_t'(in_data[OpWidth-1:0]);
    ctx0 = '0;
    ctx0.op = op;
    for (int i = 0; i < 4; i++) begin
      a[i] = in_data[OpWidth + CompWidth*i +: CompWidth];
      b[i] = in_data[OpWidth + CompWidth*(4+i) +: CompWidth];
      sum[i] = (op == OP_SUB) ? ((CompWidth+1)'(a[i]) - (CompWidth+1)'(b[i]))
                              : ((CompWidth+1)'(a[i]) + (CompWidth+1)'(b[i]));
      diff[i] = (CompWidth+1)'(a[i]) - (CompWidth+1)'(b[i]);
      dmag[i] = diff[i][CompWidth] ? (CompWidth+1)'(-diff[i]) : (CompWidth+1)'(diff[i]);
      near_ok[i] = (dmag[i] <= (CompWidth+1)'(tolerance));
      eq_ok[i] = (a[i] == b[i]);
      prod[i] = a[i] * b[i];
      sqr[i] = a[i] * a[i];
      ctx0.neg[i] = a[i][CompWidth-1];
      ctx0.sq[i] = sqr[i][SqWidth-1:0];
      // Clamp on overflow of the component sum or difference.
      if (sum[i][CompWidth] != sum[i][CompWidth-1]) begin
        ctx0.vfault = 1'b1;
        ctx0.vec[i] = sum[i][CompWidth] ? {1'b1, {(CompWidth-1){1'b0}}}
                                        : {1'b0, {(CompWidth-1){1'b1}}};
      end else begin
        ctx0.vec[i] = sum[i][CompWidth-1:0];
      end
    end
    ctx0.match = ((op == OP_NEAR) && (&near_ok)) || ((op == OP_EQ) && (&eq_ok));
  end

  // Last level of the sum trees joins the context of the item.
  always_comb begin
    ctx3 = c2;
    ctx3.dot = DotWidth'(dp2[0]) + DotWidth'(dp2[1]);
    ctx3.ssq = SumWidth'(sp2[0]) + SumWidth'(sp2[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= ctx0;
      for (int i = 0; i < 4; i++) begin
        p1[i] <= prod[i];
      end
      c2 <= c1;
      dp2[0] <= (2*CompWidth+1)'(p1[0]) + (2*CompWidth+1)'(p1[1]);
      dp2[1] <= (2*CompWidth+1)'(p1[2]) + (2*CompWidth+1)'(p1[3]);
      sp2[0] <= (2*CompWidth)'(c1.sq[0]) + (2*CompWidth)'(c1.sq[1]);
      sp2[1] <= (2*CompWidth)'(c1.sq[2]) + (2*CompWidth)'(c1.sq[3]);
      out_ctx <= ctx3;
    end
  end

endmodule

`default_nettype wire

@@ src/v4a_iter.sv @@
// One pipeline stage of the square-root and normalize digit searches.
`default_nettype none

module v4a_iter #(
  parameter int unsigned FRAC_BITS = v4a_pkg::FracBitsDefault,
  parameter int unsigned STAGE     = 0
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire v4a_pkg::ctx_t                          in_ctx,
  input  wire logic [v4a_pkg::RootBits-1:0]           in_root,
  input  wire logic [v4a_pkg::SumWidth-1:0]           in_rsq,
  input  wire logic [3:0][2*FRAC_BITS+67:0]           in_t,
  input  wire logic [3:0][FRAC_BITS+65:0]             in_u,
  input  wire logic [3:0][FRAC_BITS:0]                in_q,
  output logic                                        out_valid,
  output v4a_pkg::ctx_t                               out_ctx,
  output logic [v4a_pkg::RootBits-1:0]                out_root,
  output logic [v4a_pkg::SumWidth-1:0]                out_rsq,
  output logic [3:0][2*FRAC_BITS+67:0]                out_t,
  output logic [3:0][FRAC_BITS+65:0]                  out_u,
  output logic [3:0][FRAC_BITS:0]                     out_q
);
  import v4a_pkg::*;

  localparam int unsigned RB = RootBits - 1 - STAGE;
  localparam int unsigned SW = SumWidth + 5;
  localparam int unsigned NW = 2 * FRAC_BITS + 68;
  localparam int unsigned UW = FRAC_BITS + 66;

  logic [SW-1:0]           r_cand;
  logic                    r_ok;
  logic [RootBits-1:0]     root_next;
  logic [SumWidth-1:0]     rsq_next;
  logic [3:0][NW-1:0]      t_next;
  logic [3:0][UW-1:0]      u_next;
  logic [3:0][FRAC_BITS:0] q_next;

  // Square root: keep root squared so each trial is a shift and add.
  always_comb begin
    r_cand = SW'(in_rsq) + (SW'(in_root) << (RB + 1)) + (SW'(1) << (2 * RB));
    r_ok = (r_cand <= SW'(in_ctx.ssq));
    root_next = r_ok ? (in_root | (RootBits'(1) << RB)) : in_root;
    rsq_next = r_ok ? r_cand[SumWidth-1:0] : in_rsq;
  end

  generate
    if (STAGE <= FRAC_BITS) begin : g_norm
      localparam int unsigned NB = FRAC_BITS - STAGE;
      logic [NW-1:0] n_cand [4];
      logic [NW-1:0] n_rhs [4];
      logic [3:0]    n_ok;

      // Largest q with ssq * q^2 <= a^2 << 2F; t tracks ssq*q^2, u tracks ssq*q.
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          n_cand[i] = in_t[i] + (NW'(in_u[i]) << (NB + 1)) + (NW'(in_ctx.ssq) << (2 * NB));
          n_rhs[i] = NW'(in_ctx.sq[i]) << (2 * FRAC_BITS);
          n_ok[i] = (n_cand[i] <= n_rhs[i]);
          t_next[i] = n_ok[i] ? n_cand[i] : in_t[i];
          u_next[i] = n_ok[i] ? (in_u[i] + (UW'(in_ctx.ssq) << NB)) : in_u[i];
          q_next[i] = n_ok[i] ? (in_q[i] | ((FRAC_BITS+1)'(1) << NB)) : in_q[i];
        end
      end
    end else begin : g_pass
      always_comb begin
        t_next = in_t;
        u_next = in_u;
        q_next = in_q;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= in_ctx;
      out_root <= root_next;
      out_rsq <= rsq_next;
      out_t <= t_next;
      out_u <= u_next;
      out_q <= q_next;
    end
  end

endmodule

`default_nettype wire

@@ src/v4a_back.sv @@
// Output stage: picks the result of the opcode, saturates, and holds the result item.
`default_nettype none

module v4a_back #(
  parameter int unsigned FRAC_BITS = v4a_pkg::FracBitsDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire v4a_pkg::ctx_t                     in_ctx,
  input  wire logic [v4a_pkg::RootBits-1:0]      in_root,
  input  wire logic [3:0][FRAC_BITS:0]           in_q,
  output logic                                   out_valid,
  output logic [v4a_pkg::OutWidth-1:0]           out_data
);
  import v4a_pkg::*;

  localparam logic signed [DotWidth-1:0] DotMax = DotWidth'({1'b0, {(CompWidth-1){1'b1}}});
  localparam logic signed [DotWidth-1:0] DotMin = -DotMax - DotWidth'(1);
  localparam logic [CompWidth-1:0] PosMax = {1'b0, {(CompWidth-1){1'b1}}};
  localparam logic [CompWidth-1:0] NegMin = {1'b1, {(CompWidth-1){1'b0}}};

  logic signed [DotWidth-1:0] dsh;
  logic [3:0][CompWidth-1:0]  r;
  logic                       match;
  logic                       fault;

  always_comb begin
    dsh = in_ctx.dot >>> FRAC_BITS;
    r = '0;
    match = 1'b0;
    fault = 1'b0;
    case (in_ctx.op)
      OP_ADD, OP_SUB: begin
        r = in_ctx.vec;
        fault = in_ctx.vfault;
      end
      OP_DOT: begin
        if (dsh > DotMax) begin
          r[0] = PosMax;
          fault = 1'b1;
        end else if (dsh < DotMin) begin
          r[0] = NegMin;
          fault = 1'b1;
        end else begin
          r[0] = dsh[CompWidth-1:0];
        end
      end
      OP_LEN: begin
        if (in_root > RootBits'(PosMax)) begin
          r[0] = PosMax;
          fault = 1'b1;
        end else begin
          r[0] = in_root[CompWidth-1:0];
        end
      end
      OP_NORM: begin
        if (in_ctx.ssq == '0) begin
          fault = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            r[i] = in_ctx.neg[i] ? -CompWidth'(in_q[i]) : CompWidth'(in_q[i]);
          end
        end
      end
      OP_NEAR, OP_EQ: begin
        match = in_ctx.match;
      end
      default: begin
        fault = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= OutWidth'({fault, match, r});
    end
  end

endmodule

`default_nettype wire

@@ src/v4a_checker.sv @@
// Port-level checker for the vector ALU, bound to the top level.
`default_nettype none

`include "vec4_vector_alu_core_macros.svh"

module v4a_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata,
  input wire logic         pready
);

  `V4A_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result item valid right after reset")
  `V4A_ASSERT(a_ready_follows_out, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
  `V4A_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result item changed")
  `V4A_ASSERT(a_match_clean, m_tvalid && m_tdata[128] |-> m_tdata[127:0] == 128'd0 && !m_tdata[129], "compare result carries lanes or fault")
  `V4A_ASSERT_ALWAYS(a_pready_high, pready, "configuration port not ready")

endmodule

bind vec4_vector_alu_core v4a_checker u_v4a_checker (.*);

`default_nettype wire

@@ sim/vec4_vector_alu_checker.sv @@
// Result checker for the vector ALU: predicts each result item and compares it field by field.
module vec4_vector_alu_checker #(
  parameter int unsigned FRAC_BITS = 16,
  parameter logic [v4a_pkg::AddrWidth-1:0] TOL_ADDR = '0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [v4a_pkg::InWidth-1:0]      s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [v4a_pkg::OutWidth-1:0]     m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [v4a_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output int                               failures,
  output int                               outstanding,
  output int                               checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import v4a_pkg::*;

  typedef struct packed {
    logic              fault;
    logic              match;
    logic [3:0][31:0]  lane;
  } alu_result_t;

  logic [TolWidth-1:0] tolerance;
  alu_result_t         expected_results[$];

  function automatic logic [31:0] clamp32(logic signed [65:0] v, inout logic fault);
    if (v > 66'sh7fffffff) begin
      fault = 1'b1;
      return 32'h7fffffff;
    end else if (v < -66'sh80000000) begin
      fault = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic alu_result_t vector_alu(logic [InWidth-1:0] d, logic [TolWidth-1:0] tol);
    alu_result_t       res;
    logic [2:0]        op;
    logic signed [32:0] sa, sb, df;
    logic [32:0]       mg;
    logic signed [65:0] acc;
    logic [127:0]      ssq, rhs, cand;
    logic [63:0]       root, q;
    res = '0;
    op = d[2:0];
    ssq = '0;
    for (int i = 0; i < 4; i++) begin
      sa = $signed(d[3 + 32*i +: 32]);
      mg = (sa < 0) ? -sa : sa;
      ssq += 128'(mg) * 128'(mg);
    end
    case (op)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          sa = $signed(d[3 + 32*i +: 32]);
          sb = $signed(d[131 + 32*i +: 32]);
          acc = (op == OP_ADD) ? sa + sb : sa - sb;
          res.lane[i] = clamp32(acc, res.fault);
        end
      end
      OP_DOT: begin
        acc = '0;
        for (int i = 0; i < 4; i++) begin
          sa = $signed(d[3 + 32*i +: 32]);
          sb = $signed(d[131 + 32*i +: 32]);
          acc += 66'(sa) * 66'(sb);
        end
        // Arithmetic shift floors toward minus infinity.
        res.lane[0] = clamp32(acc >>> FRAC_BITS, res.fault);
      end
      OP_LEN: begin
        root = '0;
        for (int k = 33; k >= 0; k--) begin
          cand = 128'(root | (64'd1 << k));
          if (cand * cand <= ssq) root = cand[63:0];
        end
        res.lane[0] = clamp32($signed({2'b00, root}), res.fault);
      end
      OP_NORM: begin
        if (ssq == 0) begin
          res.fault = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            sa = $signed(d[3 + 32*i +: 32]);
            mg = (sa < 0) ? -sa : sa;
            rhs = (128'(mg) * 128'(mg)) << (2 * FRAC_BITS);
            q = '0;
            for (int k = FRAC_BITS; k >= 0; k--) begin
              cand = 128'(q | (64'd1 << k));
              if (ssq * (cand * cand) <= rhs) q = cand[63:0];
            end
            acc = (sa < 0) ? -$signed({2'b00, q}) : $signed({2'b00, q});
            res.lane[i] = clamp32(acc, res.fault);
          end
        end
      end
      OP_NEAR, OP_EQ: begin
        res.match = 1'b1;
        for (int i = 0; i < 4; i++) begin
          sa = $signed(d[3 + 32*i +: 32]);
          sb = $signed(d[131 + 32*i +: 32]);
          df = sa - sb;
          mg = (df < 0) ? -df : df;
          if (op == OP_EQ ? (sa != sb) : (mg > 33'(tol))) res.match = 1'b0;
        end
      end
      default: res.fault = 1'b1;
    endcase
    return res;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    alu_result_t exp_r, got_r;
    int          errs;
    errs = 0;
    if (rst) begin
      tolerance <= TolReset;
      failures <= 0;
      checked <= 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TOL_ADDR)
        tolerance <= pwdata[TolWidth-1:0];
      // The item accepted at this edge still sees the old tolerance.
      if (s_tvalid && s_tready)
        expected_results.push_back(vector_alu(s_tdata, tolerance));
      if (m_tvalid && m_tready) begin
        got_r = m_tdata[129:0];
        checked <= checked + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result item with nothing expected: %h", $time, got_r);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          for (int i = 0; i < 4; i++)
            if (exp_r.lane[i] !== got_r.lane[i]) begin
              $display("%0t: lane %0d expected %h actual %h", $time, i,
                       exp_r.lane[i], got_r.lane[i]);
              errs++;
            end
          if (exp_r.match !== got_r.match) begin
            $display("%0t: match expected %b actual %b", $time, exp_r.match, got_r.match);
            errs++;
          end
          if (exp_r.fault !== got_r.fault) begin
            $display("%0t: fault expected %b actual %b", $time, exp_r.fault, got_r.fault);
            errs++;
          end
        end
        failures <= failures + errs;
      end
    end
  end
endmodule

@@ sim/testbench.sv @@
// Stimulus, configuration writes and verdict for the vector ALU testbench.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import v4a_pkg::*;

  // The tolerance register is the only register, at byte address zero.
  localparam logic [AddrWidth-1:0] ADDR_TOLERANCE = '0;
  localparam logic [2:0] OP_BAD = 3'd7;
  // Watchdog limit: the run ends once nothing is accepted on any port for longer than this.
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 150;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready;
  logic [InWidth-1:0]    s_tdata;   // op, a_x..a_w, b_x..b_w from bit 0 up
  logic                  m_tvalid, m_tready;
  logic [OutWidth-1:0]   m_tdata;   // r_x, r_y, r_z, r_w, match, fault from bit 0 up
  logic                  psel, penable, pwrite, pready;
  logic [AddrWidth-1:0]  paddr;
  logic [31:0]           pwdata, prdata;

  int   failures, outstanding, checked;
  int   items_sent;
  int   idle_cycles;
  int   gap_max;
  bit   hold_req;
  logic [30:0] cur_tol;

  vec4_vector_alu_core dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  vec4_vector_alu_checker #(.TOL_ADDR(ADDR_TOLERANCE)) u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .failures, .outstanding, .checked
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a run that stops accepting anything on any port is declared dead.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d idle cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [InWidth-1:0] pack_item(logic [2:0] op, logic [3:0][31:0] va,
                                                   logic [3:0][31:0] vb);
    return {5'b0, vb, va, op};
  endfunction

  // Component values lean toward the extremes and small magnitudes.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return 32'h80000000;
      1:       return 32'h7fffffff;
      2:       return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [InWidth-1:0] item);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    // tready is stable by the falling edge, so the handshake at the next rising edge is known.
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic write_tolerance(logic [30:0] value);
    s_tvalid <= 1'b0;
    // The block must be empty before its register changes.
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_TOLERANCE;
    pwdata  <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_tol = value;
  endtask

  task automatic send_random_item();
    logic [2:0]       op;
    logic [3:0][31:0] va, vb;
    logic [31:0]      delta;
    op = ($urandom_range(0, 99) < 3) ? OP_BAD : 3'($urandom_range(0, 6));
    for (int i = 0; i < 4; i++) begin
      va[i] = rand_comp();
      vb[i] = rand_comp();
    end
    // Compares mostly see vectors that lie near each other.
    if ((op == OP_NEAR || op == OP_EQ) && $urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 5))
          0:       delta = {1'b0, cur_tol};
          1:       delta = {1'b0, cur_tol} + 32'd1;
          2:       delta = -{1'b0, cur_tol};
          3:       delta = 32'(int'($urandom_range(0, 512)) - 256);
          default: delta = 32'd0;
        endcase
        vb[i] = va[i] + delta;
      end
    end
    send_item(pack_item(op, va, vb));
  endtask

  // Result side: a random stall before each result unless gaps are off, plus one long hold on request.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = (gap_max == 0) ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    logic [30:0] tol_plan[5];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    hold_req = 1'b0;
    gap_max  = 14;
    items_sent = 0;
    cur_tol  = TolReset;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset tolerance: extremes, every opcode, zero normalize.
    send_item(pack_item(OP_ADD, {4{32'h7fffffff}}, {4{32'h00000001}}));
    send_item(pack_item(OP_ADD, {4{32'h80000000}}, {4{32'h80000000}}));
    send_item(pack_item(OP_ADD, {32'h1, 32'hffff0000, 32'h0, 32'h12345678},
                        {32'h2, 32'h00010000, 32'h0, 32'hedcba987}));
    send_item(pack_item(OP_SUB, {4{32'h80000000}}, {4{32'h00000001}}));
    send_item(pack_item(OP_SUB, {4{32'h7fffffff}}, {4{32'h80000000}}));
    send_item(pack_item(OP_SUB, {4{32'h00030000}}, {4{32'h00010000}}));
    send_item(pack_item(OP_DOT, {4{32'h80000000}}, {4{32'h80000000}}));
    send_item(pack_item(OP_DOT, {4{32'h7fffffff}}, {4{32'h80000000}}));
    send_item(pack_item(OP_DOT, {32'h0, 32'h0, 32'h0, 32'hffffffff}, {32'h0, 32'h0, 32'h0, 32'h1}));
    send_item(pack_item(OP_DOT, {4{32'h00010000}}, {4{32'h00020000}}));
    send_item(pack_item(OP_LEN, {4{32'h80000000}}, '0));
    send_item(pack_item(OP_LEN, {32'h0, 32'h0, 32'h00040000, 32'h00030000}, '0));
    send_item(pack_item(OP_LEN, '0, '0));
    send_item(pack_item(OP_LEN, {32'h0, 32'h0, 32'h0, 32'h7fffffff}, '0));
    send_item(pack_item(OP_NORM, '0, {4{32'hffffffff}}));
    send_item(pack_item(OP_NORM, {4{32'h80000000}}, '0));
    send_item(pack_item(OP_NORM, {32'h0, 32'h0, 32'hfffc0000, 32'h00030000}, '0));
    send_item(pack_item(OP_NORM, {32'h0, 32'h0, 32'h0, 32'h00000001}, '0));
    send_item(pack_item(OP_NEAR, {4{32'h00010000}}, {4{32'h00010042}}));
    send_item(pack_item(OP_NEAR, {4{32'h00010000}}, {4{32'h00010043}}));
    send_item(pack_item(OP_NEAR, {4{32'h7fffffff}}, {4{32'h80000000}}));
    send_item(pack_item(OP_EQ, {4{32'h80000000}}, {4{32'h80000000}}));
    send_item(pack_item(OP_EQ, {32'h1, 32'h2, 32'h3, 32'h4}, {32'h1, 32'h2, 32'h3, 32'h5}));
    send_item(pack_item(OP_BAD, {4{32'hffffffff}}, {4{32'hffffffff}}));

    // Random phases, each at its own tolerance; the extremes come first.
    tol_plan[0] = 31'd0;
    tol_plan[1] = 31'h7fffffff;
    tol_plan[2] = 31'($urandom_range(0, 1 << 20));
    tol_plan[3] = 31'($urandom);
    tol_plan[4] = TolReset;
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tol_plan[ph]);
      for (int n = 0; n < 106; n++) begin
        // Every 40 items decide whether this stretch runs with or without gaps.
        if (n % 40 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
        // Once, the result side holds off while items keep coming, filling the pipeline.
        if (ph == 2 && n == 50) begin
          gap_max = 0;
          hold_req = 1'b1;
        end
        send_random_item();
      end
      gap_max = 14;
    end
    s_tvalid <= 1'b0;

    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d items and checked %0d results across all seven operations,", items_sent,
             checked);
    $display("the unknown opcode and tolerances from zero to the largest value.");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/v4a_pkg.sv
src/v4a_front.sv
src/v4a_iter.sv
src/v4a_back.sv
src/vec4_vector_alu_core.sv
src/v4a_checker.sv
sim/vec4_vector_alu_checker.sv
sim/testbench.sv
